### rtl/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg
// Shared types, constants and interpolation tables of the waveshaper.
// ----------------------------------------------------------------------------
package aws_pkg;

  localparam int EXP_DEPTH = 256;
  localparam int SC_LAT = 7;
  localparam int RECIP_FRAC = 23;
  localparam int DIV_BITS = RECIP_FRAC + 33;

  localparam logic [32:0] Q_ONE = 33'h1_0000_0000;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [1:0] {
    MODE_AMP  = 2'd0,
    MODE_FUZZ = 2'd1,
    MODE_DIST = 2'd2,
    MODE_RECT = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_MODE = 1'b0,
    CFG_GAIN = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RCP_IDLE,
    RCP_EXP,
    RCP_LOOK,
    RCP_MUL,
    RCP_DEN,
    RCP_DIV
  } rcp_state_t;

  typedef logic [32:0] tab_t [0:EXP_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-k/depth) in Q32, power series of e^(-k ln2 / depth)
  function automatic tab_t build_exp_tab();
    tab_t tab;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    for (int k = 0; k <= EXP_DEPTH; k++) begin
      x = (64'(k) * 64'(LN2_Q32)) / 64'(EXP_DEPTH);
      sum = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * x) >> 32) / 64'(n);
        if ((n % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
      tab[k] = sum[32:0];
    end
    return tab;
  endfunction

  function automatic tab_t build_sqrt_tab();
    tab_t tab;
    logic [63:0] r;
    for (int k = 0; k <= EXP_DEPTH; k++) begin
      if (k < EXP_DEPTH) begin
        r = isqrt64(((64'(k) << 32) / 64'(EXP_DEPTH)) << 32);
        tab[k] = r[32:0];
      end else begin
        tab[k] = Q_ONE;
      end
    end
    return tab;
  endfunction

  localparam tab_t EXP_TAB = build_exp_tab();
  localparam tab_t SQRT_TAB = build_sqrt_tab();

endpackage

### rtl/aws_stream_if.sv
// ----------------------------------------------------------------------------
// aws_in_if / aws_out_if
// Valid/ready sample channels of the waveshaper.
// ----------------------------------------------------------------------------
interface aws_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface aws_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

### rtl/audio_waveshaper_top.sv
// A sample passes in_r, delay line a, mid_r, delay line b and the output register in turn.
// Throughput: one sample per cycle through the two seven-stage soft clip pipelines when not stalled by out_if.ready.
// Reset (synchronous, rst_n low): mode amp, gain 1.0, pipeline emptied.
// After reset and after each gain write the normaliser reciprocal is rebuilt by a
// 56-step serial divider; input is held off meanwhile.
// ----------------------------------------------------------------------------
// audio_waveshaper_top
// Exponential soft clip waveshaper with amp, fuzz, distortion and rectify modes.
// ----------------------------------------------------------------------------
module audio_waveshaper_top import aws_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  aws_in_if.sink     in_if,
  aws_out_if.source  out_if,
  input  logic       cfg_wr_en,
  input  cfg_idx_t   cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int FRAC_BITS = SAMPLE_BITS - 1;
  localparam int Q_SHIFT = 33 - SAMPLE_BITS;

  typedef struct packed {
    logic        valid;
    logic        neg;
    mode_t       mode;
    logic        sq_ok;
    logic [32:0] m;
  } side_t;

  // configuration and reciprocal
  mode_t       mode_r;
  logic [15:0] gain_r;
  logic [15:0] geff;
  logic [31:0] recip_r;

  rcp_state_t  rcp_state_r;
  rcp_state_t  rcp_state_nxt;
  logic        rcp_busy;

  logic [40:0] r_u_r;
  logic        r_big_r;
  logic [4:0]  r_n_r;
  logic        r_zero_r;
  logic [32:0] r_hi_r;
  logic [32:0] r_diff_r;
  logic [23:0] r_fr_r;
  logic [56:0] r_prod_r;
  logic [32:0] r_hi_nxt;
  logic [32:0] r_lo_nxt;
  logic [32:0] r_v;
  logic [32:0] r_e;
  logic [32:0] den_r;
  logic [33:0] rem_r;
  logic [33:0] rem_nxt;
  logic [33:0] rsh;
  logic        r_ge;
  logic [DIV_BITS-1:0] quo_r;
  logic [DIV_BITS-1:0] quo_nxt;
  logic [5:0]  cnt_r;

  // pipeline
  logic        en;
  logic        in_ready;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic        raw_neg;
  side_t       in_nxt;
  side_t       in_r;
  side_t       line_a_r [SC_LAT];
  side_t       mid_nxt;
  side_t       mid_r;
  side_t       line_b_r [SC_LAT];

  logic [32:0] sc_a_y;
  logic [32:0] sc_b_y;

  logic [32:0] sq_a_r;
  logic [32:0] sq_d_r;
  logic [23:0] sq_f_r;
  logic [32:0] sq_a2_r;
  logic [56:0] sq_p_r;
  logic [32:0] sq_line_r [SC_LAT-2];
  logic [32:0] sq_hi;
  logic [32:0] sq_lo;

  logic [32:0] fin_v;
  logic [34:0] fin_h3;
  logic [33:0] fin_h;
  logic [32:0] fin_hard;
  logic [32:0] fin_m;
  logic [33:0] fin_q;
  logic [33:0] fin_qc;
  logic [SAMPLE_BITS-1:0] fin_qs;
  logic [SAMPLE_BITS-1:0] out_sample_nxt;

  logic        out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_AMP;
      gain_r <= 16'd256;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_MODE) mode_r <= mode_t'(cfg_data[1:0]);
      else gain_r <= cfg_data;
    end
  end

  assign geff = (gain_r == 16'd0) ? 16'd1 : gain_r;

  // reciprocal sequencer
  always_comb begin
    rcp_state_nxt = rcp_state_r;
    unique case (rcp_state_r)
      RCP_IDLE: rcp_state_nxt = RCP_IDLE;
      RCP_EXP:  rcp_state_nxt = RCP_LOOK;
      RCP_LOOK: rcp_state_nxt = RCP_MUL;
      RCP_MUL:  rcp_state_nxt = RCP_DEN;
      RCP_DEN:  rcp_state_nxt = RCP_DIV;
      RCP_DIV:  rcp_state_nxt = (cnt_r == 6'd0) ? RCP_IDLE : RCP_DIV;
      default:  rcp_state_nxt = RCP_IDLE;
    endcase
    if (cfg_wr_en && cfg_index == CFG_GAIN) rcp_state_nxt = RCP_EXP;
  end

  always_comb begin
    rcp_busy = (rcp_state_r != RCP_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rcp_state_r <= RCP_EXP;
    else rcp_state_r <= rcp_state_nxt;
  end

  always_comb begin
    r_hi_nxt = EXP_TAB[{1'b0, r_u_r[31:24]}];
    r_lo_nxt = EXP_TAB[9'({1'b0, r_u_r[31:24]}) + 9'd1];
    r_v = r_hi_r - 33'(r_prod_r >> 24);
    r_e = r_zero_r ? 33'd0 : (r_v >> r_n_r);
    rsh = {rem_r[32:0], (cnt_r == 6'(DIV_BITS - 1))};
    r_ge = (rsh >= {1'b0, den_r});
    rem_nxt = r_ge ? (rsh - {1'b0, den_r}) : rsh;
    quo_nxt = {quo_r[DIV_BITS-2:0], r_ge};
  end

  always_ff @(posedge clk) begin
    unique case (rcp_state_r)
      RCP_EXP: begin
        r_u_r   <= 41'(geff) * 41'(LOG2E_Q24);
        r_big_r <= |geff[15:13];
      end
      RCP_LOOK: begin
        r_n_r    <= r_u_r[36:32];
        r_zero_r <= r_big_r | (|r_u_r[40:37]);
        r_hi_r   <= r_hi_nxt;
        r_diff_r <= (r_hi_nxt > r_lo_nxt) ? (r_hi_nxt - r_lo_nxt) : 33'd0;
        r_fr_r   <= r_u_r[23:0];
      end
      RCP_MUL: begin
        r_prod_r <= 57'(r_diff_r) * 57'(r_fr_r);
      end
      RCP_DEN: begin
        den_r <= Q_ONE - r_e;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 6'(DIV_BITS - 1);
      end
      RCP_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          recip_r <= (|quo_nxt[DIV_BITS-1:32]) ? 32'hFFFF_FFFF : quo_nxt[31:0];
        end
      end
      default: ;
    endcase
  end

  // input stage
  assign en       = !out_valid_r || out_if.ready;
  assign in_ready = en && !rcp_busy;
  assign in_if.ready = in_ready;

  always_comb begin
    raw = in_if.sample_in;
    raw_neg = raw[SAMPLE_BITS-1];
    mag = raw_neg ? SAMPLE_BITS'(~raw + 1'b1) : raw;
    in_nxt.valid = in_if.valid && in_ready;
    in_nxt.neg   = raw_neg;
    in_nxt.mode  = mode_r;
    in_nxt.m     = 33'(mag) << Q_SHIFT;
    in_nxt.sq_ok = !raw_neg && (mag != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid <= 1'b0;
      for (int k = 0; k < SC_LAT; k++) begin
        line_a_r[k].valid <= 1'b0;
        line_b_r[k].valid <= 1'b0;
      end
      mid_r.valid <= 1'b0;
    end else if (en) begin
      in_r <= in_nxt;
      line_a_r[0] <= in_r;
      for (int k = 1; k < SC_LAT; k++) line_a_r[k] <= line_a_r[k-1];
      mid_r <= mid_nxt;
      line_b_r[0] <= mid_r;
      for (int k = 1; k < SC_LAT; k++) line_b_r[k] <= line_b_r[k-1];
    end
  end

  // first shaping pass with square root alongside
  aws_softclip u_sc_a (
    .clk     (clk),
    .en      (en),
    .m_i     (in_r.m),
    .gain_i  (geff),
    .recip_i (recip_r),
    .y_o     (sc_a_y)
  );

  always_comb begin
    sq_hi = SQRT_TAB[{1'b0, in_r.m[31:24]}];
    sq_lo = SQRT_TAB[9'({1'b0, in_r.m[31:24]}) + 9'd1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a_r  <= sq_hi;
      sq_d_r  <= (sq_lo > sq_hi) ? (sq_lo - sq_hi) : 33'd0;
      sq_f_r  <= in_r.m[23:0];
      sq_a2_r <= sq_a_r;
      sq_p_r  <= 57'(sq_d_r) * 57'(sq_f_r);
      sq_line_r[0] <= sq_a2_r + 33'(sq_p_r >> 24);
      for (int k = 1; k < SC_LAT - 2; k++) sq_line_r[k] <= sq_line_r[k-1];
    end
  end

  always_comb begin
    mid_nxt = line_a_r[SC_LAT-1];
    unique case (line_a_r[SC_LAT-1].mode)
      MODE_AMP, MODE_FUZZ: mid_nxt.m = sc_a_y;
      MODE_DIST: mid_nxt.m = line_a_r[SC_LAT-1].sq_ok ? sq_line_r[SC_LAT-3] : sc_a_y;
      MODE_RECT: begin
        mid_nxt.m   = line_a_r[SC_LAT-1].m;
        mid_nxt.neg = 1'b0;
      end
      default: mid_nxt.m = sc_a_y;
    endcase
  end

  // second shaping pass
  aws_softclip u_sc_b (
    .clk     (clk),
    .en      (en),
    .m_i     (mid_r.m),
    .gain_i  (geff),
    .recip_i (recip_r),
    .y_o     (sc_b_y)
  );

  always_comb begin
    fin_v    = line_b_r[SC_LAT-1].m;
    fin_h3   = {1'b0, fin_v, 1'b0} + 35'(fin_v);
    fin_h    = fin_h3[34:1];
    fin_hard = (fin_h > 34'(Q_ONE)) ? Q_ONE : fin_h[32:0];
    unique case (line_b_r[SC_LAT-1].mode)
      MODE_AMP, MODE_RECT: fin_m = fin_v;
      MODE_FUZZ: fin_m = sc_b_y;
      MODE_DIST: begin
        fin_m = (!line_b_r[SC_LAT-1].neg && fin_v != 33'd0) ? sc_b_y : fin_hard;
      end
      default: fin_m = fin_v;
    endcase
    fin_q = (34'(fin_m) + (34'(1) << (Q_SHIFT - 1))) >> Q_SHIFT;
    if (line_b_r[SC_LAT-1].neg) begin
      fin_qc = (fin_q > (34'(1) << FRAC_BITS)) ? (34'(1) << FRAC_BITS) : fin_q;
    end else begin
      fin_qc = (fin_q > ((34'(1) << FRAC_BITS) - 34'd1)) ?
               ((34'(1) << FRAC_BITS) - 34'd1) : fin_q;
    end
    fin_qs = SAMPLE_BITS'(fin_qc);
    out_sample_nxt = line_b_r[SC_LAT-1].neg ? SAMPLE_BITS'(~fin_qs + 1'b1) : fin_qs;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= line_b_r[SC_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_sample_r <= out_sample_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;

endmodule

### rtl/aws_softclip.sv
// ----------------------------------------------------------------------------
// aws_softclip
// Seven-stage normalised exponential soft clip on a Q32 magnitude.
// ----------------------------------------------------------------------------
module aws_softclip import aws_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] m_i,
  input  logic [15:0] gain_i,
  input  logic [31:0] recip_i,
  output logic [32:0] y_o
);

  logic [48:0] gm;
  logic [40:0] t_r;
  logic        big1_r;

  logic [43:0] ph_r;
  logic [42:0] pl_r;
  logic        big2_r;

  logic [61:0] usum;
  logic [37:0] u;
  logic [4:0]  n3_r;
  logic        zero3_r;
  logic [7:0]  idx3_r;
  logic [23:0] fr3_r;

  logic [32:0] hi_nxt;
  logic [32:0] lo_nxt;
  logic [32:0] hi4_r;
  logic [32:0] diff4_r;
  logic [4:0]  n4_r;
  logic        zero4_r;
  logic [23:0] fr4_r;

  logic [56:0] prod5_r;
  logic [32:0] hi5_r;
  logic [4:0]  n5_r;
  logic        zero5_r;

  logic [32:0] v6;
  logic [32:0] e6;
  logic [32:0] num6_r;

  logic [64:0] yy;
  logic [41:0] ys;
  logic [32:0] y_r;

  always_comb begin
    gm = 49'(gain_i) * 49'(m_i);
    usum = {ph_r, 18'b0} + 62'(pl_r);
    u = usum[61:24];
    hi_nxt = EXP_TAB[{1'b0, idx3_r}];
    lo_nxt = EXP_TAB[9'({1'b0, idx3_r}) + 9'd1];
    v6 = hi5_r - 33'(prod5_r >> 24);
    e6 = zero5_r ? 33'd0 : (v6 >> n5_r);
    yy = 65'(num6_r) * 65'(recip_i);
    ys = yy[64:RECIP_FRAC];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= gm[48:8];
      big1_r  <= |gm[48:45];
      ph_r    <= 44'(t_r[36:18]) * 44'(LOG2E_Q24);
      pl_r    <= 43'(t_r[17:0]) * 43'(LOG2E_Q24);
      big2_r  <= big1_r;
      n3_r    <= u[36:32];
      zero3_r <= big2_r | u[37];
      idx3_r  <= u[31:24];
      fr3_r   <= u[23:0];
      hi4_r   <= hi_nxt;
      diff4_r <= (hi_nxt > lo_nxt) ? (hi_nxt - lo_nxt) : 33'd0;
      n4_r    <= n3_r;
      zero4_r <= zero3_r;
      fr4_r   <= fr3_r;
      prod5_r <= 57'(diff4_r) * 57'(fr4_r);
      hi5_r   <= hi4_r;
      n5_r    <= n4_r;
      zero5_r <= zero4_r;
      num6_r  <= Q_ONE - e6;
      y_r     <= (ys > 42'(Q_ONE)) ? Q_ONE : ys[32:0];
    end
  end

  assign y_o = y_r;

endmodule

### dv/tb_audio_waveshaper_top.sv
// ----------------------------------------------------------------------------
// tb_audio_waveshaper_top
// Self-checking bench for the waveshaper. A queue of samples feeds a driver,
// a monitor compares each output transaction with a predicted sample, and the
// mode and gain are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_audio_waveshaper_top;
  import aws_pkg::*;

  localparam int SB = 24;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] LO32 = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  cfg_idx_t cfg_index = CFG_MODE;
  logic [15:0] cfg_data = '0;

  aws_in_if #(.SAMPLE_BITS(SB)) in_if ();
  aws_out_if #(.SAMPLE_BITS(SB)) out_if ();

  audio_waveshaper_top #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [63:0] exp_lut [0:256];
  logic [63:0] sqrt_lut [0:256];
  mode_t shp_mode;
  logic [15:0] shp_gain;
  logic [31:0] shp_recip;

  logic [SB-1:0] pending_samples [$];
  logic [SB-1:0] expected_samples [$];
  int errors = 0;
  int hold_cycles = 0;
  bit stall_en = 1'b1;

  function automatic logic [63:0] root64(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in; r = 0; b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic fill_luts();
    logic [63:0] x, s, t;
    for (int k = 0; k <= 256; k++) begin
      x = (64'(k) * 64'd2977044472) / 64'd256;
      s = ONE_Q32; t = ONE_Q32;
      for (int n = 1; n <= 24; n++) begin
        t = ((t * x) >> 32) / 64'(n);
        if (n % 2 == 1) s = s - t;
        else s = s + t;
      end
      exp_lut[k] = s;
      sqrt_lut[k] = (k < 256) ? root64(((64'(k) << 32) / 64'd256) << 32) : ONE_Q32;
    end
  endtask

  function automatic logic [63:0] decay(input logic [63:0] t);
    logic [63:0] u, n, f, p, idx, rem, hi, lo, d, v;
    logic [127:0] w;
    if (t >= (64'd32 << 32)) return 0;
    w = 128'(t) * 128'd24204406;
    u = 64'(w >> 24);
    n = u >> 32;
    if (n >= 32) return 0;
    f = u & LO32;
    p = f * 256;
    idx = p >> 32;
    rem = p & LO32;
    hi = exp_lut[idx];
    lo = exp_lut[idx + 1];
    d = hi > lo ? hi - lo : 0;
    v = hi - ((d * rem) >> 32);
    return v >> n;
  endfunction

  function automatic logic [63:0] eff_gain();
    return (shp_gain == 0) ? 64'd1 : 64'(shp_gain);
  endfunction

  task automatic rebuild_recip();
    logic [63:0] den, r;
    den = ONE_Q32 - decay(eff_gain() << 24);
    r = (den != 0) ? ((64'd1 << 55) / den) : LO32;
    shp_recip = (r > LO32) ? 32'hFFFF_FFFF : r[31:0];
  endtask

  function automatic logic [63:0] clip_soft(input logic [63:0] m);
    logic [63:0] num, y;
    num = ONE_Q32 - decay((eff_gain() * m) >> 8);
    y = (num * 64'(shp_recip)) >> 23;
    return y > ONE_Q32 ? ONE_Q32 : y;
  endfunction

  function automatic logic [63:0] root_q32(input logic [63:0] m);
    logic [63:0] p, idx, rem, a, b, d;
    if (m >= ONE_Q32) return ONE_Q32;
    p = m * 256;
    idx = p >> 32;
    rem = p & LO32;
    a = sqrt_lut[idx];
    b = sqrt_lut[idx + 1];
    d = b > a ? b - a : 0;
    return a + ((d * rem) >> 32);
  endfunction

  function automatic logic [SB-1:0] shape_sample(input logic [SB-1:0] raw);
    logic neg;
    logic [63:0] m, q;
    neg = raw[SB-1];
    m = (neg ? ((64'd1 << SB) - 64'(raw)) : 64'(raw)) << (32 - (SB - 1));
    case (shp_mode)
      MODE_AMP: m = clip_soft(m);
      MODE_FUZZ: m = clip_soft(clip_soft(m));
      MODE_DIST: begin
        if (!neg && m != 0) m = root_q32(m);
        else m = clip_soft(m);
        if (!neg && m != 0) m = clip_soft(m);
        else begin
          m = (3 * m) >> 1;
          if (m > ONE_Q32) m = ONE_Q32;
        end
      end
      default: neg = 1'b0;
    endcase
    q = (m + (64'd1 << (32 - SB))) >> (33 - SB);
    if (neg) begin
      if (q > (64'd1 << (SB - 1))) q = 64'd1 << (SB - 1);
      return SB'((64'd1 << SB) - q);
    end
    if (q > (64'd1 << (SB - 1)) - 1) q = (64'd1 << (SB - 1)) - 1;
    return SB'(q);
  endfunction

  task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                 input logic [SB-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input transaction taken at the last rising edge
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken <= rst_n && in_if.valid && in_if.ready;
  end

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (in_taken) begin
        expected_samples.push_back(shape_sample(in_if.sample_in));
        void'(pending_samples.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.sample_in <= pending_samples[0];
        if (stall_en) in_gap = gap_len();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver readiness
  int out_gap = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (stall_en) out_gap = gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected transaction", out_if.sample_out, '0);
      end else begin
        if (out_if.sample_out !== expected_samples[0])
          report_mismatch("sample_out", out_if.sample_out, expected_samples[0]);
        void'(expected_samples.pop_front());
      end
    end
  end

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_if.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MODE) shp_mode = mode_t'(val[1:0]);
    else begin
      shp_gain = val;
      rebuild_recip();
    end
  endtask

  function automatic logic [SB-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SB'($urandom_range(0, 15));
    if (r == 1) return ~SB'($urandom_range(0, 15));
    if (r == 2) return {r[0], {(SB-1){~r[0]}}};
    return SB'($urandom);
  endfunction

  task automatic directed_set();
    pending_samples.push_back(24'h000000);
    pending_samples.push_back(24'h7FFFFF);
    pending_samples.push_back(24'h800000);
    pending_samples.push_back(24'h000001);
    pending_samples.push_back(24'hFFFFFF);
    pending_samples.push_back(24'h400000);
    pending_samples.push_back(24'hC00000);
    pending_samples.push_back(24'h555555);
    pending_samples.push_back(24'hAAAAAA);
  endtask

  initial begin
    logic [15:0] gains [0:6];
    gains = '{16'd0, 16'd1, 16'd256, 16'd65535, 16'd32768, 16'd1024, 16'd77};
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
    fill_luts();
    shp_mode = MODE_AMP;
    shp_gain = 16'd256;
    rebuild_recip();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int m = 0; m < 4; m++) begin
      directed_set();
      wait_idle();
      write_reg(CFG_MODE, 16'(m + 1) & 16'h3);
    end

    stall_en = 1'b0;
    hold_cycles = 200;
    for (int i = 0; i < 100; i++) pending_samples.push_back(rand_sample());
    wait_idle();
    stall_en = 1'b1;

    for (int ph = 0; ph < 14; ph++) begin
      write_reg(CFG_MODE, 16'(ph % 4));
      write_reg(CFG_GAIN, gains[ph % 7]);
      if (ph == 7) stall_en = 1'b0;
      if (ph == 9) stall_en = 1'b1;
      directed_set();
      for (int i = 0; i < 115; i++) pending_samples.push_back(rand_sample());
      wait_idle();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
